### rtl/mtss_pkg.sv
// Shared types, register indexes and sine table math for the multi-tone synthesizer.
// Depends on nothing; the RTL files refer to it by scoped names and the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package mtss_pkg;

  localparam int MAX_TONES       = 2;
  localparam int TONES_DEF       = 2;
  localparam int TABLE_BITS_DEF  = 10;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int PHASE_W         = 32;
  localparam int AMP_W           = 16;
  localparam int COUNT_W         = 16;
  localparam int SINE_W          = 16;
  localparam int SAMPLE_W        = 17;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 16'd1024;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TONE0_STEP  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE0_START = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE0_AMP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE1_STEP  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE1_START = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE1_AMP   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_CNT  = 3'd6;

  typedef struct packed {
    logic [MAX_TONES-1:0][PHASE_W-1:0] phase_step;
    logic [MAX_TONES-1:0][PHASE_W-1:0] start_phase;
    logic [MAX_TONES-1:0][AMP_W-1:0]   amplitude;
    logic [COUNT_W-1:0]                sample_count;
  } cfg_t;

  // Quarter-wave entry k of a table with 2^table_bits entries, in Q1.15.
  // Eleven-term Taylor series in Q30 with truncating steps, clamped to zero and one.
  function automatic logic [SINE_W-1:0] quarter_sine(input int k, input int table_bits);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x    = (longint'(k) * 64'sd6746518852) >>> table_bits;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;   sum = sum - term;
    term = ((term * x2) >>> 30) / 20;  sum = sum + term;
    term = ((term * x2) >>> 30) / 42;  sum = sum - term;
    term = ((term * x2) >>> 30) / 72;  sum = sum + term;
    term = ((term * x2) >>> 30) / 110; sum = sum - term;
    term = ((term * x2) >>> 30) / 156; sum = sum + term;
    term = ((term * x2) >>> 30) / 210; sum = sum - term;
    term = ((term * x2) >>> 30) / 272; sum = sum + term;
    term = ((term * x2) >>> 30) / 342; sum = sum - term;
    term = ((term * x2) >>> 30) / 420; sum = sum + term;
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return SINE_W'((sum * 32767 + (64'sd1 <<< 29)) >>> 30);
  endfunction

endpackage

`default_nettype wire

### rtl/mtss_cfg_regs.sv
// Configuration register file of the multi-tone synthesizer.
// Depends on mtss_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module mtss_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [mtss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [mtss_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mtss_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= '0;
      cfg.start_phase  <= '0;
      cfg.amplitude    <= '0;
      cfg.sample_count <= mtss_pkg::SAMPLE_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mtss_pkg::REG_TONE0_STEP:  cfg.phase_step[0]  <= cfg_data;
        mtss_pkg::REG_TONE0_START: cfg.start_phase[0] <= cfg_data;
        mtss_pkg::REG_TONE0_AMP:   cfg.amplitude[0]   <= cfg_data[mtss_pkg::AMP_W-1:0];
        mtss_pkg::REG_TONE1_STEP:  cfg.phase_step[1]  <= cfg_data;
        mtss_pkg::REG_TONE1_START: cfg.start_phase[1] <= cfg_data;
        mtss_pkg::REG_TONE1_AMP:   cfg.amplitude[1]   <= cfg_data[mtss_pkg::AMP_W-1:0];
        mtss_pkg::REG_SAMPLE_CNT:  cfg.sample_count   <= cfg_data[mtss_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/mtss_sine_rom.sv
// Quarter-wave sine ROM with quadrant folding and a registered read port.
// Depends on mtss_pkg for the table entry function and widths.
`timescale 1ns / 1ps
`default_nettype none

module mtss_sine_rom #(
  parameter int SINE_TABLE_BITS = mtss_pkg::TABLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              enable,
  input  wire logic [SINE_TABLE_BITS-1:0]        table_index,
  output logic      [mtss_pkg::SINE_W-1:0]       magnitude,
  output logic                                   negate
);

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int ADDR_W  = SINE_TABLE_BITS - 1;

  typedef logic [mtss_pkg::SINE_W-1:0] rom_t [QUARTER+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= QUARTER; k++) begin
      r[k] = mtss_pkg::quarter_sine(k, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [1:0]        quadrant;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] rom_addr;

  assign quadrant = table_index[SINE_TABLE_BITS-1 -: 2];
  assign offset   = {1'b0, table_index[SINE_TABLE_BITS-3:0]};
  // Second and fourth quadrants run the quarter wave backwards.
  assign rom_addr = quadrant[0] ? (ADDR_W'(QUARTER) - offset) : offset;

  always_ff @(posedge clk) begin
    if (enable) begin
      magnitude <= ROM[rom_addr];
      negate    <= quadrant[1];
    end
  end

endmodule

`default_nettype wire

### rtl/multi_tone_sine_synthesizer.sv
// Top level of the multi-tone direct digital sine synthesizer.
// Depends on mtss_pkg, mtss_cfg_regs and mtss_sine_rom.
`timescale 1ns / 1ps
`default_nettype none

// Each tick transfer produces one sample transfer: the sum of up to two sine
// tones, each read from a quarter-wave ROM addressed by the top bits of a
// 32-bit phase accumulator and scaled by a signed Q1.15 amplitude. The block
// takes one tick per clock while tick_ready is high; the phase accumulators
// and sample counter update in the same cycle a tick is accepted, and the
// sample is registered through the datapath's three stages (ROM read,
// multiply, sum), each of which accepts a new item whenever it is empty or
// its contents move on, so a waiting sample does not stop ticks
// until all three stages are full. A tick with restart set reloads the start
// phases before its sample is formed. The last sample of every run of
// sample_count samples has run_end set, and the next sample starts again from
// the start phases; a count of zero acts as one. The ROM is a constant table,
// so there is no fill or clearing pass after reset. Configuration writes are
// meant for idle periods: a new start phase applies at the next run start,
// a new step at the next phase advance.

module multi_tone_sine_synthesizer #(
  parameter int TONES           = mtss_pkg::TONES_DEF,
  parameter int SINE_TABLE_BITS = mtss_pkg::TABLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration write port.
  input  wire logic                                 cfg_write,
  input  wire logic [mtss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mtss_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Tick channel.
  input  wire logic                                 tick_valid,
  output logic                                      tick_ready,
  input  wire logic                                 restart,
  // Sample channel.
  output logic                                      result_valid,
  input  wire logic                                 result_ready,
  output logic signed [mtss_pkg::SAMPLE_W-1:0]      sample_value,
  output logic                                      run_end
);

  localparam int PW = mtss_pkg::PHASE_W;
  localparam int CW = mtss_pkg::COUNT_W;
  localparam int SW = mtss_pkg::SINE_W;
  localparam int AW = mtss_pkg::AMP_W;

  mtss_pkg::cfg_t cfg;

  mtss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic en1;
  logic en2;
  logic en3;
  logic valid1;
  logic valid2;
  logic accept;

  assign en3        = !result_valid || result_ready;
  assign en2        = !valid2 || en3;
  assign en1        = !valid1 || en2;
  assign tick_ready = en1;
  assign accept     = tick_valid && tick_ready;

  // Phase accumulators and the sample counter.
  logic [PW-1:0] tone_phase  [TONES];
  logic [PW-1:0] phase_base  [TONES];
  logic [CW-1:0] sample_index;
  logic [CW-1:0] index_base;
  logic [CW:0]   index_inc;
  logic          last_now;

  assign index_base = restart ? '0 : sample_index;
  assign index_inc  = {1'b0, index_base} + (CW+1)'(1);
  // An index at or past the end, as after lowering the count, also ends the run.
  assign last_now   = index_inc >= {1'b0, cfg.sample_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (accept) begin
      sample_index <= last_now ? '0 : index_inc[CW-1:0];
    end
  end

  // Stage one holds the ROM read; stage two the products.
  logic [SW-1:0]        rom_mag  [TONES];
  logic                 rom_neg  [TONES];
  logic [AW-1:0]        amp1     [TONES];
  logic signed [31:0]   prod2    [TONES];
  logic                 last1;
  logic                 last2;

  for (genvar t = 0; t < TONES; t++) begin : g_tone
    logic signed [SW-1:0] sine_val;

    assign phase_base[t] = restart ? cfg.start_phase[t] : tone_phase[t];

    always_ff @(posedge clk) begin
      if (rst) begin
        tone_phase[t] <= '0;
      end else if (accept) begin
        tone_phase[t] <= last_now ? cfg.start_phase[t] : phase_base[t] + cfg.phase_step[t];
      end
    end

    mtss_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
      .clk         (clk),
      .enable      (en1),
      .table_index (phase_base[t][PW-1 -: SINE_TABLE_BITS]),
      .magnitude   (rom_mag[t]),
      .negate      (rom_neg[t])
    );

    always_ff @(posedge clk) begin
      if (en1) begin
        amp1[t] <= cfg.amplitude[t];
      end
    end

    assign sine_val = rom_neg[t] ? -$signed(rom_mag[t]) : $signed(rom_mag[t]);

    always_ff @(posedge clk) begin
      if (en2) begin
        prod2[t] <= sine_val * $signed(amp1[t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      last1 <= last_now;
    end
    if (en2) begin
      last2 <= last1;
    end
  end

  // Stage three: floor-shift each product by 15 and add the tones. The shifted
  // value always fits in 16 bits, so bits 30 down to 15 carry it exactly.
  logic signed [mtss_pkg::SAMPLE_W-1:0] tone_sum;

  always_comb begin
    tone_sum = '0;
    for (int t = 0; t < TONES; t++) begin
      tone_sum = tone_sum + mtss_pkg::SAMPLE_W'($signed(prod2[t][30:15]));
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sample_value <= tone_sum;
      run_end      <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1       <= 1'b0;
      valid2       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) valid1       <= accept;
      if (en2) valid2       <= valid1;
      if (en3) result_valid <= valid2;
    end
  end

`ifndef NO_ASSERTIONS
  // Ticks are refused only when every stage holds a sample.
  a_ready_full : assert property (@(posedge clk) disable iff (rst)
    !tick_ready |-> (valid1 && valid2 && result_valid))
    else $error("tick refused while the pipeline has room");

  // The sample that ends a run leaves the counter at the start of the next run.
  a_run_wrap : assert property (@(posedge clk) disable iff (rst)
    (accept && last_now) |=> (sample_index == '0))
    else $error("sample counter did not wrap at run end");

  // A stalled stage three keeps its sample.
  a_stage_hold : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(sample_value)
      && $stable(run_end)))
    else $error("waiting sample changed");

  // Nothing comes out in the cycle after reset.
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("sample valid right after reset");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_multi_tone_sine_synthesizer.sv
// Self-checking testbench for the two-tone sine synthesizer: directed and random ticks,
// with a per-tick predictor of each sample. Depends on mtss_pkg and the synthesizer RTL.
`timescale 1ns / 1ps

module tb_multi_tone_sine_synthesizer;

  import mtss_pkg::*;

  localparam int TONE_COUNT = TONES_DEF;
  localparam int LUT_BITS   = TABLE_BITS_DEF;
  localparam int LUT_SIZE   = 1 << LUT_BITS;
  localparam int LUT_QTR    = LUT_SIZE / 4;

  // The port has a three-bit index, so there is one index past the register list.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // The watchdog fires after this many cycles with no transfer and no register write.
  // The longest stall of either side, from pick_gap, is far shorter, so this leaves a wide margin.
  localparam int STALL_LIMIT = 2000;

  localparam int RANDOM_TICKS = 1600;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       ends_run;
  } sample_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_write;
  logic [CFG_INDEX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        tick_valid;
  logic                        tick_ready;
  logic                        restart;
  logic                        result_valid;
  logic                        result_ready;
  logic signed [SAMPLE_W-1:0]  sample_value;
  logic                        run_end;

  multi_tone_sine_synthesizer uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .restart      (restart),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_value (sample_value),
    .run_end      (run_end)
  );

  // Shadow copy of the register file and the synthesizer state. These are updated
  // only by the monitor below, on the same clock edges that the block sees.
  logic [PHASE_W-1:0]        tone_step  [TONE_COUNT];
  logic [PHASE_W-1:0]        tone_start [TONE_COUNT];
  logic signed [AMP_W-1:0]   tone_amp   [TONE_COUNT];
  logic [COUNT_W-1:0]        run_length;
  logic [PHASE_W-1:0]        tone_phase [TONE_COUNT];
  logic [COUNT_W-1:0]        sample_index;

  // Full-wave sine lookup in Q1.15, built once at time zero.
  logic signed [SINE_W-1:0]  sine_lut   [LUT_SIZE];

  // Samples predicted for accepted ticks and not yet seen on the output.
  sample_t                   pending_samples [$];

  int                        mismatch_count;
  int                        stall_cycles;

  // Knobs that the tests flip to turn source gaps and sink stalls on and off.
  bit                        source_gaps;
  bit                        sink_stalls;

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is held from time zero and released on a falling edge,
  // so the first rising edge after it sees clean inputs.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sine table. The quarter wave comes from an eleven-term Taylor series in Q30
  // with truncating shifts and divisions, clamped to zero and one and rounded to
  // Q1.15. The other three quadrants are mirrored from it.
  // ---------------------------------------------------------------------------
  initial begin : build_sine_lut
    logic signed [SINE_W-1:0] quarter [LUT_QTR + 1];
    longint unsigned          angle;
    longint unsigned          angle_sq;
    longint unsigned          term;
    longint                   series;
    int                       quad;
    int                       offs;
    for (int k = 0; k <= LUT_QTR; k++) begin
      angle    = (longint'(k) * 64'd6746518852) >> LUT_BITS;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      series   = angle;
      for (int n = 1; n <= 10; n++) begin
        term = (term * angle_sq) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          series = series - longint'(term);
        end else begin
          series = series + longint'(term);
        end
      end
      if (series < 0) begin
        series = 0;
      end
      if (series > (64'sd1 <<< 30)) begin
        series = 64'sd1 <<< 30;
      end
      quarter[k] = SINE_W'((series * 32767 + (64'sd1 <<< 29)) >>> 30);
    end
    for (int k = 0; k < LUT_SIZE; k++) begin
      quad = k / LUT_QTR;
      offs = k % LUT_QTR;
      case (quad)
        0: begin
          sine_lut[k] = quarter[offs];
        end
        1: begin
          sine_lut[k] = quarter[LUT_QTR - offs];
        end
        2: begin
          sine_lut[k] = -quarter[offs];
        end
        default: begin
          sine_lut[k] = -quarter[LUT_QTR - offs];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor. One call per accepted tick: a restart reloads the start phases
  // first, then each tone reads the table at the top phase bits, scales by its
  // amplitude with an arithmetic shift of 15, and the tones are summed. The last
  // sample of a run (including an index already past a lowered count, and any
  // sample when the count is zero) reloads the start phases; every other sample
  // advances the phases and the index.
  // ---------------------------------------------------------------------------
  task automatic synth_next_sample(input logic reload, output sample_t predicted);
    int                 acc;
    logic signed [31:0] scaled;
    logic [COUNT_W:0]   next_index;
    if (reload) begin
      for (int t = 0; t < TONE_COUNT; t++) begin
        tone_phase[t] = tone_start[t];
      end
      sample_index = '0;
    end
    acc = 0;
    for (int t = 0; t < TONE_COUNT; t++) begin
      scaled = sine_lut[tone_phase[t][PHASE_W-1 -: LUT_BITS]] * tone_amp[t];
      acc    = acc + (scaled >>> 15);
    end
    next_index         = {1'b0, sample_index} + 1'b1;
    predicted.value    = acc[SAMPLE_W-1:0];
    predicted.ends_run = (next_index >= {1'b0, run_length});
    if (predicted.ends_run) begin
      for (int t = 0; t < TONE_COUNT; t++) begin
        tone_phase[t] = tone_start[t];
      end
      sample_index = '0;
    end else begin
      for (int t = 0; t < TONE_COUNT; t++) begin
        tone_phase[t] = tone_phase[t] + tone_step[t];
      end
      sample_index = sample_index + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers move. Register writes update the shadow copy, a tick transfer appends
  // its predicted sample, and a sample transfer is checked against the oldest one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    sample_t predicted;
    sample_t oldest;
    if (rst) begin
      for (int t = 0; t < TONE_COUNT; t++) begin
        tone_step[t]  = '0;
        tone_start[t] = '0;
        tone_amp[t]   = '0;
        tone_phase[t] = '0;
      end
      run_length   = SAMPLE_COUNT_RESET;
      sample_index = '0;
      pending_samples.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TONE0_STEP: begin
            tone_step[0] = cfg_data;
          end
          REG_TONE0_START: begin
            tone_start[0] = cfg_data;
          end
          REG_TONE0_AMP: begin
            tone_amp[0] = cfg_data[AMP_W-1:0];
          end
          REG_TONE1_STEP: begin
            tone_step[1] = cfg_data;
          end
          REG_TONE1_START: begin
            tone_start[1] = cfg_data;
          end
          REG_TONE1_AMP: begin
            tone_amp[1] = cfg_data[AMP_W-1:0];
          end
          REG_SAMPLE_CNT: begin
            run_length = cfg_data[COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (tick_valid && tick_ready) begin
        synth_next_sample(restart, predicted);
        pending_samples = {pending_samples, predicted};
      end
      if (result_valid && result_ready) begin
        if (pending_samples.size() == 0) begin
          $error("sample transfer with no tick waiting for it: sample_value %0d, run_end %0b",
                 sample_value, run_end);
          mismatch_count++;
        end else begin
          oldest = pending_samples.pop_front();
          if (sample_value !== oldest.value) begin
            $error("sample_value mismatch: expected %0d, actual %0d",
                   oldest.value, sample_value);
            mismatch_count++;
          end
          if (run_end !== oldest.ends_run) begin
            $error("run_end mismatch: expected %0b, actual %0b", oldest.ends_run, run_end);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (tick_valid && tick_ready) || (result_valid && result_ready) || cfg_write) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Gap lengths: mostly none, often short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  // Sample sink. Ready changes only on falling edges; with stalls off it stays high.
  initial begin : sample_sink
    int gap;
    result_ready = 1'b1;
    forever begin
      @(negedge clk);
      gap = sink_stalls ? pick_gap() : 0;
      if (gap > 0) begin
        result_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers.
  // ---------------------------------------------------------------------------

  // Offer one tick and hold it until the transfer. Back-to-back ticks keep valid
  // high; only a gap lowers it, and then on an earlier falling edge than the raise.
  task automatic send_tick(input logic reload);
    int gap;
    gap = source_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      tick_valid = 1'b0;
      restart    = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    tick_valid = 1'b1;
    restart    = reload;
    do begin
      @(posedge clk);
    end while (!tick_ready);
  endtask

  // Drop valid and wait until every predicted sample has come out.
  task automatic drain_samples();
    @(negedge clk);
    tick_valid = 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic program_tones(input logic [31:0] step0, input logic [31:0] start0,
                               input logic [31:0] amp0, input logic [31:0] step1,
                               input logic [31:0] start1, input logic [31:0] amp1,
                               input logic [31:0] count);
    write_reg(REG_TONE0_STEP, step0);
    write_reg(REG_TONE0_START, start0);
    write_reg(REG_TONE0_AMP, amp0);
    write_reg(REG_TONE1_STEP, step1);
    write_reg(REG_TONE1_START, start1);
    write_reg(REG_TONE1_AMP, amp1);
    write_reg(REG_SAMPLE_CNT, count);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Right after reset both amplitudes are zero, so every sample is zero and no
  // run ends before 1024 samples. A restart in the middle must not change that.
  task automatic test_reset_state();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    for (int i = 0; i < 6; i++) begin
      send_tick(i == 3);
    end
    drain_samples();
  endtask

  // Full-scale amplitudes of both signs, one table step per sample on tone zero
  // and a step of all ones on tone one. Both tones start at three quarters of a
  // turn, where two negative full-scale amplitudes give the largest positive sum.
  // The second half silences tone one to check that a zero amplitude adds nothing.
  task automatic test_tone_extremes();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    program_tones(32'h0040_0000, 32'hC000_0000, 32'h0000_8000,
                  32'hFFFF_FFFF, 32'hC000_0000, 32'hFFFF_8000, 32'd5);
    for (int i = 0; i < 7; i++) begin
      send_tick(i == 0 || i == 4);
    end
    drain_samples();
    program_tones(32'hFFFF_FFFF, 32'h4000_0000, 32'h0000_7FFF,
                  32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'd3);
    for (int i = 0; i < 5; i++) begin
      send_tick(i == 0);
    end
    drain_samples();
  endtask

  // A count of one and a count of zero: every sample ends its run and the phases
  // never leave the start values. Sink stalls are on here.
  task automatic test_short_runs();
    source_gaps = 1'b0;
    sink_stalls = 1'b1;
    program_tones(32'h1234_5678, 32'h2000_0000, 32'h0000_4000,
                  32'h0800_0000, 32'h6000_0000, 32'h0000_C000, 32'd1);
    for (int i = 0; i < 3; i++) begin
      send_tick(1'b0);
    end
    drain_samples();
    write_reg(REG_SAMPLE_CNT, 32'd0);
    for (int i = 0; i < 3; i++) begin
      send_tick(i == 1);
    end
    drain_samples();
  endtask

  // The count is lowered below the current index between ticks: the very next
  // sample must be marked as a run end and the run starts over. A write past the
  // register list must leave everything as it was.
  task automatic test_count_lowered();
    source_gaps = 1'b1;
    sink_stalls = 1'b0;
    write_reg(REG_SAMPLE_CNT, 32'd20);
    for (int i = 0; i < 10; i++) begin
      send_tick(i == 0);
    end
    drain_samples();
    write_reg(REG_SAMPLE_CNT, 32'd4);
    write_reg(REG_UNUSED, $urandom);
    for (int i = 0; i < 6; i++) begin
      send_tick(1'b0);
    end
    drain_samples();
  endtask

  function automatic logic [31:0] pick_phase_word();
    case ($urandom_range(0, 5))
      0: begin
        return 32'h0000_0000;
      end
      1: begin
        return 32'hFFFF_FFFF;
      end
      2, 3: begin
        return $urandom_range(0, 1 << 24);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Upper bits of the word are random; only the low 16 bits are the amplitude.
  function automatic logic [31:0] pick_amp_word();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(0, 5))
      0: begin
        word[15:0] = 16'h7FFF;
      end
      1: begin
        word[15:0] = 16'h8000;
      end
      2: begin
        word[15:0] = 16'h0000;
      end
      default: begin
      end
    endcase
    return word;
  endfunction

  // Runs are mostly short so that many run ends occur; the extremes show up too.
  function automatic logic [31:0] pick_count_word();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        word[15:0] = 16'h0000;
      end
      1: begin
        word[15:0] = 16'hFFFF;
      end
      2: begin
        word[15:0] = 16'h0001;
      end
      3: begin
      end
      default: begin
        word[15:0] = 16'($urandom_range(2, 48));
      end
    endcase
    return word;
  endfunction

  // Random phases: fresh settings for every register while idle, a random mix of
  // source gaps and sink stalls (sometimes neither), then a burst of ticks with an
  // occasional restart. Each phase drains fully before the next one writes.
  task automatic test_random_tones();
    int ticks_sent;
    int burst;
    int restart_pct;
    ticks_sent = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      program_tones(pick_phase_word(), $urandom, pick_amp_word(),
                    pick_phase_word(), $urandom, pick_amp_word(), pick_count_word());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, $urandom);
      end
      source_gaps = ($urandom_range(0, 2) != 0);
      sink_stalls = ($urandom_range(0, 2) != 0);
      restart_pct = $urandom_range(0, 10);
      burst       = $urandom_range(30, 150);
      for (int i = 0; i < burst; i++) begin
        send_tick(i == 0 || $urandom_range(0, 99) < restart_pct);
      end
      ticks_sent += burst;
      drain_samples();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    source_gaps    = 1'b0;
    sink_stalls    = 1'b0;
    tick_valid     = 1'b0;
    restart        = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    @(negedge rst);
    test_reset_state();
    test_tone_extremes();
    test_short_runs();
    test_count_lowered();
    test_random_tones();
    drain_samples();
    // Keep clocking to catch any sample transfer nobody asked for.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mtss_pkg.sv
rtl/mtss_cfg_regs.sv
rtl/mtss_sine_rom.sv
rtl/multi_tone_sine_synthesizer.sv
tb/sv/tb_multi_tone_sine_synthesizer.sv
